// File: src/button_node_id_setter_assert.svh
// Assertion macros used by the button node ID setter checker.
`ifndef BUTTON_NODE_ID_SETTER_ASSERT_SVH
`define BUTTON_NODE_ID_SETTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BNID_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BNID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bnid_pkg.sv
// Shared types and constants of the button node ID setter.
package bnid_pkg;

  // ID value that means no ID is stored
  localparam int unsigned NO_ID_CODE = 15;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [3:0]  NODE_ID_RST    = 4'd15;
  localparam logic [15:0] LONG_PRESS_RST = 16'd300;
  localparam logic [15:0] TIMEOUT_RST    = 16'd300;
  localparam logic [7:0]  BLINK_RST      = 8'd20;
  localparam logic [9:0]  PAUSE_RST      = 10'd100;
  // pause modulo blink half period at reset
  localparam logic [7:0]  PAUSE_REM_RST  = 8'(PAUSE_RST % BLINK_RST);

  localparam logic [3:0]  LINK_RELOAD = 4'd10;
  localparam logic [15:0] CNT_MAX     = 16'hFFFF;
  localparam logic [3:0]  REM_LAST    = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_ID       = 3'd0,
    REG_LONG_PRESS    = 3'd1,
    REG_ENTRY_TIMEOUT = 3'd2,
    REG_BLINK         = 3'd3,
    REG_PAUSE         = 3'd4
  } reg_idx_e;

  // Configuration as seen by the datapath (blink already forced nonzero)
  typedef struct packed {
    logic [3:0]  node_id;
    logic [15:0] long_press;
    logic [15:0] entry_timeout;
    logic [7:0]  blink;
    logic [9:0]  pause;
  } cfg_t;

  // Remainder unit results
  typedef struct packed {
    logic       done;
    logic [7:0] pat_rem;
    logic [7:0] pause_rem;
  } rem_res_t;

  // One result item
  typedef struct packed {
    logic       led_id;
    logic       led_tx;
    logic       led_rx;
    logic       entry_active;
    logic       commit_valid;
    logic [3:0] commit_id;
  } result_t;

endpackage

// File: src/bnid_cfg.sv
// Configuration register file of the button node ID setter.
module bnid_cfg import bnid_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  rem_busy_i,
  output logic                  rem_start_o,
  output cfg_t                  cfg_o
);

  logic [3:0]  node_id_q;
  logic [15:0] long_press_q;
  logic [15:0] timeout_q;
  logic [7:0]  blink_q;
  logic [9:0]  pause_q;
  logic        start_q;
  logic        wr;

  // no writes while remainders are being recomputed
  assign cfg_ready_o = !rem_busy_i && !start_q;
  assign wr          = cfg_valid_i && cfg_ready_o;
  assign rem_start_o = start_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= NODE_ID_RST;
      long_press_q <= LONG_PRESS_RST;
      timeout_q    <= TIMEOUT_RST;
      blink_q      <= BLINK_RST;
      pause_q      <= PAUSE_RST;
      start_q      <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (wr) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_NODE_ID:       node_id_q    <= cfg_data_i[3:0];
          REG_LONG_PRESS:    long_press_q <= cfg_data_i;
          REG_ENTRY_TIMEOUT: timeout_q    <= cfg_data_i;
          REG_BLINK: begin
            blink_q <= cfg_data_i[7:0];
            start_q <= 1'b1;
          end
          REG_PAUSE: begin
            pause_q <= cfg_data_i[9:0];
            start_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // zero half period behaves as one
  always_comb begin
    cfg_o.node_id       = node_id_q;
    cfg_o.long_press    = long_press_q;
    cfg_o.entry_timeout = timeout_q;
    cfg_o.blink         = (blink_q == 8'd0) ? 8'd1 : blink_q;
    cfg_o.pause         = pause_q;
  end

endmodule

// File: src/bnid_rem.sv
// Bit-serial remainder unit: pattern count and pause modulo the blink half period.
module bnid_rem import bnid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] pattern_i,
  input  logic [9:0]  pause_i,
  input  logic [7:0]  divisor_i,
  output logic        busy_o,
  output rem_res_t    res_o
);

  logic        busy_q;
  logic        done_q;
  logic [3:0]  cnt_q;
  logic [15:0] pat_sh_q;
  logic [15:0] pse_sh_q;
  logic [7:0]  pat_rem_q;
  logic [7:0]  pse_rem_q;
  logic [7:0]  pat_rem_d;
  logic [7:0]  pse_rem_d;

  // one restoring step: shift in a dividend bit, subtract if it fits
  function automatic logic [7:0] rem_step(input logic [7:0] r, input logic b_in,
                                          input logic [7:0] d);
    logic [8:0] t;
    t = {r, b_in};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[7:0];
  endfunction

  assign pat_rem_d = rem_step(pat_rem_q, pat_sh_q[15], divisor_i);
  assign pse_rem_d = rem_step(pse_rem_q, pse_sh_q[15], divisor_i);

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= REM_LAST;
      end else if (busy_q) begin
        if (cnt_q == 4'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 4'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pat_sh_q  <= pattern_i;
      pse_sh_q  <= {6'd0, pause_i};
      pat_rem_q <= 8'd0;
      pse_rem_q <= 8'd0;
    end else if (busy_q) begin
      pat_sh_q  <= {pat_sh_q[14:0], 1'b0};
      pse_sh_q  <= {pse_sh_q[14:0], 1'b0};
      pat_rem_q <= pat_rem_d;
      pse_rem_q <= pse_rem_d;
    end
  end

  assign busy_o          = busy_q || done_q;
  assign res_o.done      = done_q;
  assign res_o.pat_rem   = pat_rem_q;
  assign res_o.pause_rem = pse_rem_q;

endmodule

// File: src/bnid_core.sv
// Per-tick state update: debouncer, long press, ID entry and ID LED pattern.
module bnid_core import bnid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        button_i,
  input  logic        safety_i,
  input  cfg_t        cfg_i,
  input  rem_res_t    rem_i,
  output logic [15:0] pattern_o,
  output result_t     res_o
);

  logic        db_first_q, db_first_d;
  logic        db_second_q, db_second_d;
  logic [15:0] hold_q, hold_d;
  logic [15:0] pat_q, pat_d;
  logic [7:0]  pmod_q, pmod_d;
  logic [7:0]  rmod_q;
  logic        led_q, led_d;
  logic        entry_q, entry_d;
  logic [15:0] press_q, press_d;
  logic        pflag_q, pflag_d;
  logic [15:0] idle_q, idle_d;
  logic [3:0]  link_cnt_q, link_cnt_d;
  logic [1:0]  link_q, link_d;

  logic        btn;
  logic        btn_edge;
  logic        enter;
  logic        run_led;
  logic        cvalid;
  logic [3:0]  cid;
  logic [5:0]  mult_k;
  logic [13:0] prod;
  logic [15:0] reload;
  logic [10:0] dark_lim;

  // ID pattern length: blink * (2 * id + 3) + pause
  assign mult_k   = {1'b0, cfg_i.node_id, 1'b1} + 6'd2;
  assign prod     = {6'd0, cfg_i.blink} * {8'd0, mult_k};
  assign reload   = {2'd0, prod} + {6'd0, cfg_i.pause};
  assign dark_lim = {1'b0, cfg_i.pause} + {3'd0, cfg_i.blink};

  // two-bit debouncer
  always_comb begin
    db_first_d  = db_first_q;
    db_second_d = db_second_q;
    if (button_i) begin
      if (db_first_q) begin
        db_second_d = 1'b1;
        btn         = 1'b1;
      end else begin
        db_first_d = 1'b1;
        btn        = db_second_q;
      end
    end else begin
      if (!db_first_q) begin
        db_second_d = 1'b0;
        btn         = 1'b0;
      end else begin
        db_first_d = 1'b0;
        btn        = db_second_q;
      end
    end
  end

  // mode logic, then the ID LED pattern where it runs
  always_comb begin
    hold_d     = hold_q;
    pat_d      = pat_q;
    pmod_d     = pmod_q;
    led_d      = led_q;
    entry_d    = entry_q;
    press_d    = press_q;
    pflag_d    = pflag_q;
    idle_d     = idle_q;
    link_cnt_d = link_cnt_q;
    link_d     = link_q;
    btn_edge   = 1'b0;
    enter      = 1'b0;
    run_led    = 1'b0;
    cvalid     = 1'b0;
    cid        = 4'd0;

    if (entry_q) begin
      // count presses, LED follows button
      if (btn && !pflag_q) begin
        if (press_q != CNT_MAX) press_d = press_q + 16'd1;
        led_d    = 1'b1;
        pflag_d  = 1'b1;
        btn_edge = 1'b1;
      end else if (!btn && pflag_q) begin
        led_d    = 1'b0;
        pflag_d  = 1'b0;
        btn_edge = 1'b1;
      end
      // TX/RX alternate every 11 ticks
      if (link_cnt_q == 4'd0) begin
        link_d     = link_q ^ 2'b11;
        link_cnt_d = LINK_RELOAD;
      end else begin
        link_cnt_d = link_cnt_q - 4'd1;
      end
      if (btn_edge) idle_d = 16'd1;
      else if (idle_q != CNT_MAX) idle_d = idle_q + 16'd1;
      // timeout ends entry and may commit
      if (idle_d >= cfg_i.entry_timeout) begin
        entry_d = 1'b0;
        link_d  = 2'b00;
        hold_d  = 16'd0;
        if (press_d != 16'd0 && press_d <= 16'(NO_ID_CODE)) begin
          cvalid = 1'b1;
          cid    = press_d[3:0] - 4'd1;
        end
        run_led = 1'b1;
      end
    end else begin
      // long press detection
      if (safety_i) begin
        if (btn) begin
          if (hold_q != CNT_MAX) hold_d = hold_q + 16'd1;
        end else begin
          enter  = (hold_q >= cfg_i.long_press);
          hold_d = 16'd0;
        end
      end else begin
        hold_d = 16'd0;
      end
      if (enter) begin
        entry_d    = 1'b1;
        press_d    = 16'd0;
        pflag_d    = 1'b0;
        idle_d     = 16'd0;
        link_cnt_d = LINK_RELOAD;
        link_d     = 2'b01;
      end else begin
        run_led = 1'b1;
      end
    end

    // ID LED pattern; pmod tracks pattern count modulo blink
    if (run_led) begin
      if ({4'd0, cfg_i.node_id} == 8'(NO_ID_CODE)) begin
        led_d = 1'b1;
      end else if (hold_d >= cfg_i.long_press) begin
        led_d = 1'b0;
      end else begin
        if (pat_q <= {5'd0, dark_lim}) led_d = 1'b0;
        else if (pmod_q == 8'd0) led_d = !led_d;
        if (pat_q == 16'd0) begin
          pat_d  = reload;
          pmod_d = rmod_q;
        end else begin
          pat_d  = pat_q - 16'd1;
          pmod_d = (pmod_q == 8'd0) ? cfg_i.blink - 8'd1 : pmod_q - 8'd1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_first_q  <= 1'b0;
      db_second_q <= 1'b0;
      hold_q      <= 16'd0;
      pat_q       <= 16'd0;
      pmod_q      <= 8'd0;
      rmod_q      <= PAUSE_REM_RST;
      led_q       <= 1'b0;
      entry_q     <= 1'b0;
      press_q     <= 16'd0;
      pflag_q     <= 1'b0;
      idle_q      <= 16'd0;
      link_cnt_q  <= LINK_RELOAD;
      link_q      <= 2'b00;
    end else if (rem_i.done) begin
      pmod_q <= rem_i.pat_rem;
      rmod_q <= rem_i.pause_rem;
    end else if (step_i) begin
      db_first_q  <= db_first_d;
      db_second_q <= db_second_d;
      hold_q      <= hold_d;
      pat_q       <= pat_d;
      pmod_q      <= pmod_d;
      led_q       <= led_d;
      entry_q     <= entry_d;
      press_q     <= press_d;
      pflag_q     <= pflag_d;
      idle_q      <= idle_d;
      link_cnt_q  <= link_cnt_d;
      link_q      <= link_d;
    end
  end

  assign pattern_o = pat_q;

  always_comb begin
    res_o.led_id       = led_d;
    res_o.led_tx       = link_d[0];
    res_o.led_rx       = link_d[1];
    res_o.entry_active = entry_d;
    res_o.commit_valid = cvalid;
    res_o.commit_id    = cid;
  end

endmodule

// File: src/button_node_id_setter.sv
// Top level of the button node ID setter.
//
// One input transfer per 10 ms tick carries the raw button level and the
// safety enable; each tick yields exactly one result transfer with the ID,
// TX and RX LED levels, the entry mode flag and a commit strobe with the
// new ID. Both channels use valid/ready.
// A tick is captured in the input register at its transfer; its result is
// loaded into the output register once that is free and no recompute runs.
// Throughput is one tick per cycle unless a stall or recompute holds it;
// a new tick is accepted while the previous result waits, since the two
// registers move apart.
// When the receiver stalls, the output register holds its result and the
// input register fills, then in_ready_o drops until the output is taken.
// A write to the blink or pause register starts a bit-serial remainder
// recompute of the pattern phase, with cfg_ready_o and in_ready_o low.
// Reset (rst_ni low, asynchronous) restores the register defaults, clears
// all tick state and empties both pipeline registers.
module button_node_id_setter import bnid_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  button_pressed_i,
  input  logic                  safety_on_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  led_id_o,
  output logic                  led_tx_o,
  output logic                  led_rx_o,
  output logic                  entry_active_o,
  output logic                  commit_valid_o,
  output logic [3:0]            commit_id_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t        cfg;
  rem_res_t    rem_res;
  result_t     step_res;
  result_t     out_q;
  logic        rem_start;
  logic        rem_busy;
  logic        hold;
  logic        adv;
  logic [15:0] pattern;
  logic        s1_valid_q;
  logic        s1_btn_q;
  logic        s1_safety_q;
  logic        out_valid_q;

  bnid_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rem_busy_i  (rem_busy),
    .rem_start_o (rem_start),
    .cfg_o       (cfg)
  );

  bnid_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .pattern_i (pattern),
    .pause_i   (cfg.pause),
    .divisor_i (cfg.blink),
    .busy_o    (rem_busy),
    .res_o     (rem_res)
  );

  bnid_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .button_i  (s1_btn_q),
    .safety_i  (s1_safety_q),
    .cfg_i     (cfg),
    .rem_i     (rem_res),
    .pattern_o (pattern),
    .res_o     (step_res)
  );

  // handshake: tick moves to the output when the output slot is free and no recompute is pending
  assign hold       = rem_start || rem_busy;
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i) && !hold;
  assign in_ready_o = !hold && (!s1_valid_q || adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (adv) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_btn_q    <= button_pressed_i;
      s1_safety_q <= safety_on_i;
    end
    if (adv) out_q <= step_res;
  end

  assign out_valid_o    = out_valid_q;
  assign led_id_o       = out_q.led_id;
  assign led_tx_o       = out_q.led_tx;
  assign led_rx_o       = out_q.led_rx;
  assign entry_active_o = out_q.entry_active;
  assign commit_valid_o = out_q.commit_valid;
  assign commit_id_o    = out_q.commit_id;

endmodule

// File: src/bnid_checker.sv
// Port-level checker of the button node ID setter and its bind.
`include "button_node_id_setter_assert.svh"

module bnid_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       led_id_o,
  input logic       led_tx_o,
  input logic       led_rx_o,
  input logic       entry_active_o,
  input logic       commit_valid_o,
  input logic [3:0] commit_id_o
);

  logic [8:0] res_bits;

  // all result fields in one vector
  assign res_bits = {led_id_o, led_tx_o, led_rx_o, entry_active_o, commit_valid_o,
                     commit_id_o};

  // stalled result stays put
  `BNID_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(res_bits), "result changed while stalled")

  // commit ID is zero without a commit
  `BNID_ASSERT_IMPL(a_cid_zero, clk_i, rst_ni, out_valid_o && !commit_valid_o,
    commit_id_o == 4'd0, "commit ID set without commit")

  // a commit happens only on the exit tick
  `BNID_ASSERT_IMPL(a_commit_exit, clk_i, rst_ni, out_valid_o && commit_valid_o,
    !entry_active_o && !led_tx_o && !led_rx_o, "commit outside exit tick")

  // link LEDs alternate in entry mode and are dark outside it
  `BNID_ASSERT_IMPL(a_link_leds, clk_i, rst_ni, out_valid_o,
    entry_active_o ? (led_tx_o != led_rx_o) : (!led_tx_o && !led_rx_o),
    "link LED pattern broken")

endmodule

bind button_node_id_setter bnid_checker u_bnid_checker (.*);

// File: tb/button_node_id_setter_tb.sv
// Self-checking testbench for the button node ID setter.
`timescale 1ns / 1ps

module button_node_id_setter_tb;
  import bnid_pkg::*;

  localparam int unsigned PHASE_TICKS  = 170;
  localparam int unsigned RAND_PHASES  = 9;
  localparam int unsigned SETTLE_TICKS = 4;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // indexes past the last register; writes to them change nothing
  localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE = 3'd5;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  btn;
    logic                  saf;
    logic                  typed;
    result_t               want;
  } dir_row_t;

  // node ID unset: ID LED steady on, everything else quiet
  localparam result_t SHOW_NO_ID = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0};
  localparam result_t NOT_TYPED  = '0;

  // Directed stimulus: reset defaults, zero thresholds and zero blink, then a
  // broken hold, a real long press, one press and a commit on timeout.
  localparam dir_row_t DIRECTED [30] = '{
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b0, 1'b0, 1'b1, SHOW_NO_ID},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b1, 1'b1, 1'b1, SHOW_NO_ID},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b1, 1'b1, 1'b1, SHOW_NO_ID},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b0, 1'b1, 1'b1, SHOW_NO_ID},
    '{ROW_CFG,  REG_NODE_ID,       16'hFFF2, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_CFG,  REG_LONG_PRESS,    16'h0000, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_CFG,  REG_ENTRY_TIMEOUT, 16'h0000, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_CFG,  REG_BLINK,         16'hFF00, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_CFG,  REG_PAUSE,         16'hFC00, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_CFG,  REG_IDX_SPARE,     16'hFFFF, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b0, 1'b1, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b1, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_CFG,  REG_LONG_PRESS,    16'h0002, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_CFG,  REG_ENTRY_TIMEOUT, 16'h0003, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_CFG,  REG_BLINK,         16'h0001, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b1, 1'b1, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b1, 1'b1, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b1, 1'b1, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b1, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b1, 1'b1, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b1, 1'b1, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b0, 1'b1, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b0, 1'b1, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b1, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b1, 1'b1, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b0, 1'b0, 1'b0, NOT_TYPED},
    '{ROW_TICK, REG_NODE_ID,       16'h0000, 1'b0, 1'b0, 1'b0, NOT_TYPED}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic button_pressed_i;
  logic safety_on_i;
  logic out_valid_o;
  logic out_ready_i;
  logic led_id_o;
  logic led_tx_o;
  logic led_rx_o;
  logic entry_active_o;
  logic commit_valid_o;
  logic [3:0] commit_id_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Predictor copy of the registers
  logic [3:0]  cfg_node_id       = NODE_ID_RST;
  logic [15:0] cfg_long_press    = LONG_PRESS_RST;
  logic [15:0] cfg_entry_timeout = TIMEOUT_RST;
  logic [7:0]  cfg_blink         = BLINK_RST;
  logic [9:0]  cfg_pause         = PAUSE_RST;

  // Predictor copy of the tick state
  logic        db_last     = 1'b0;
  logic        db_level    = 1'b0;
  logic [15:0] held_ticks  = '0;
  logic [15:0] blink_phase = '0;
  logic        id_led      = 1'b0;
  logic        in_entry    = 1'b0;
  logic [15:0] presses     = '0;
  logic        btn_down    = 1'b0;
  logic [15:0] quiet_ticks = '0;
  logic [3:0]  link_div    = LINK_RELOAD;
  logic [1:0]  link_leds   = 2'b00;

  result_t     outcome_q [$];
  int unsigned fails      = 0;
  int unsigned ticks_sent = 0;
  bit          pace_on    = 1'b0;
  bit          stall_req  = 1'b0;

  button_node_id_setter u_top (.*);

  always #5 clk_i = ~clk_i;

  // ID LED outside entry mode: steady when unset, dark during a long hold,
  // otherwise (id + 1) pulses and a dark pause per pattern period
  function automatic void blink_id_led();
    int unsigned half;
    half = (cfg_blink == 8'd0) ? 1 : int'(cfg_blink);
    if (cfg_node_id == NO_ID_CODE) begin
      id_led = 1'b1;
    end else if (held_ticks >= cfg_long_press) begin
      id_led = 1'b0;
    end else begin
      if (blink_phase <= cfg_pause + half) id_led = 1'b0;
      else if (blink_phase % half == 0) id_led = ~id_led;
      if (blink_phase == 16'd0)
        blink_phase = 16'(((cfg_node_id + 1) * half * 2) + cfg_pause + half);
      else
        blink_phase--;
    end
  endfunction

  // Outcome of one tick; advances the predictor state
  function automatic result_t tick_outcome(input logic raw, input logic safety);
    logic    btn;
    logic    toggled;
    logic    go_entry;
    result_t r;
    r = '0;
    // two equal raw samples in a row move the debounced level
    if (raw == db_last) db_level = raw;
    db_last = raw;
    btn = db_level;
    if (in_entry) begin
      toggled = 1'b0;
      if (btn && !btn_down) begin
        if (presses != CNT_MAX) presses++;
        id_led = 1'b1;
        btn_down = 1'b1;
        toggled = 1'b1;
      end else if (!btn && btn_down) begin
        id_led = 1'b0;
        btn_down = 1'b0;
        toggled = 1'b1;
      end
      if (link_div == 4'd0) begin
        link_leds = ~link_leds;
        link_div = LINK_RELOAD;
      end else begin
        link_div--;
      end
      if (toggled) quiet_ticks = 16'd1;
      else if (quiet_ticks != CNT_MAX) quiet_ticks++;
      // timeout: leave entry mode, commit a count within the ID range
      if (quiet_ticks >= cfg_entry_timeout) begin
        in_entry = 1'b0;
        link_leds = 2'b00;
        held_ticks = '0;
        if (presses != 16'd0 && presses <= NO_ID_CODE) begin
          r.commit_valid = 1'b1;
          r.commit_id = 4'(presses - 16'd1);
        end
        blink_id_led();
      end
    end else begin
      go_entry = 1'b0;
      if (safety) begin
        if (btn) begin
          if (held_ticks != CNT_MAX) held_ticks++;
        end else begin
          go_entry = (held_ticks >= cfg_long_press);
          held_ticks = '0;
        end
      end else begin
        held_ticks = '0;
      end
      if (go_entry) begin
        in_entry = 1'b1;
        presses = '0;
        btn_down = 1'b0;
        quiet_ticks = '0;
        link_div = LINK_RELOAD;
        link_leds = 2'b01;
      end else begin
        blink_id_led();
      end
    end
    r.led_id = id_led;
    r.led_tx = link_leds[0];
    r.led_rx = link_leds[1];
    r.entry_active = in_entry;
    return r;
  endfunction

  // Random bits above the register width; the block must drop them
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] val,
                                                      input int unsigned bits);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom) << bits;
    return junk | val;
  endfunction

  // Stop offering ticks and wait until every outcome has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // One input transfer; the outcome is queued at acceptance
  task automatic send_tick(input logic raw, input logic safety,
                           input logic typed = 1'b0, input result_t want = '0);
    result_t predicted;
    if (pace_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    button_pressed_i <= raw;
    safety_on_i <= safety;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = tick_outcome(raw, safety);
    outcome_q.push_back(typed ? want : predicted);
    ticks_sent++;
  endtask

  // One register write transfer, always from idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_NODE_ID:       cfg_node_id = data[3:0];
      REG_LONG_PRESS:    cfg_long_press = data;
      REG_ENTRY_TIMEOUT: cfg_entry_timeout = data;
      REG_BLINK:         cfg_blink = data[7:0];
      REG_PAUSE:         cfg_pause = data[9:0];
      default:           ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_phase(input logic [3:0] node, input logic [15:0] lp,
                           input logic [15:0] tmo, input logic [7:0] bl,
                           input logic [9:0] pa);
    write_reg(REG_NODE_ID, with_junk(16'(node), 4));
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_ENTRY_TIMEOUT, tmo);
    write_reg(REG_BLINK, with_junk(16'(bl), 8));
    write_reg(REG_PAUSE, with_junk(16'(pa), 10));
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'(REG_IDX_SPARE + $urandom_range(0, 2)), 16'($urandom));
  endtask

  // Long press, a run of presses, then silence until the entry timeout;
  // some holds are cut short or lose safety midway
  task automatic session();
    int unsigned hold_len;
    int unsigned drop_at;
    int unsigned n_press;
    hold_len = cfg_long_press + $urandom_range(3, 5);
    if ($urandom_range(0, 4) == 0) hold_len = $urandom_range(1, cfg_long_press + 2);
    drop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, hold_len - 1) : hold_len;
    for (int i = 0; i < hold_len; i++) send_tick(1'b1, i != drop_at);
    repeat (2) send_tick(1'b0, 1'b1);
    n_press = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 15) : $urandom_range(0, 20);
    repeat (n_press) begin
      repeat ($urandom_range(1, 4)) send_tick(1'b1, 1'($urandom));
      repeat ($urandom_range(2, 5)) send_tick(1'b0, 1'($urandom));
    end
    repeat (cfg_entry_timeout + $urandom_range(1, 4)) send_tick(1'b0, 1'($urandom));
    repeat ($urandom_range(0, 40)) send_tick(1'b0, 1'($urandom));
  endtask

  // Bouncy raw level with mostly safety on
  task automatic noise_burst();
    logic raw;
    raw = 1'b0;
    repeat ($urandom_range(4, 30)) begin
      if ($urandom_range(0, 2) == 0) raw = ~raw;
      send_tick(raw, $urandom_range(0, 3) != 0);
    end
  endtask

  // Receiver: random ready bursts, one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (stall_req) begin
        out_ready_i <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
        stall_req = 1'b0;
      end else if (pace_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat (pace_on ? $urandom_range(1, 12) : 1) @(posedge clk_i);
      end
    end
  end

  // Result check against the oldest queued outcome
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outcome_q.size() == 0) begin
        $error("result transfer with no outcome queued");
        fails++;
      end else begin
        want = outcome_q.pop_front();
        if (led_id_o !== want.led_id) begin
          $error("led_id: expected %0d, got %0d", want.led_id, led_id_o);
          fails++;
        end
        if (led_tx_o !== want.led_tx) begin
          $error("led_tx: expected %0d, got %0d", want.led_tx, led_tx_o);
          fails++;
        end
        if (led_rx_o !== want.led_rx) begin
          $error("led_rx: expected %0d, got %0d", want.led_rx, led_rx_o);
          fails++;
        end
        if (entry_active_o !== want.entry_active) begin
          $error("entry_active: expected %0d, got %0d", want.entry_active, entry_active_o);
          fails++;
        end
        if (commit_valid_o !== want.commit_valid) begin
          $error("commit_valid: expected %0d, got %0d", want.commit_valid, commit_valid_o);
          fails++;
        end
        if (commit_id_o !== want.commit_id) begin
          $error("commit_id: expected %0d, got %0d", want.commit_id, commit_id_o);
          fails++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    int unsigned cycles;
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("button_node_id_setter regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned phase_start;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    button_pressed_i <= 1'b0;
    safety_on_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    pace_on = 1'b1;

    // directed rows
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG)
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      else
        send_tick(DIRECTED[i].btn, DIRECTED[i].saf, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // random phases, register extremes first
    for (int k = 0; k < RAND_PHASES; k++) begin
      // last phase runs with no idling on either side
      if (k == int'(RAND_PHASES) - 1) pace_on = 1'b0;
      case (k)
        0: set_phase(4'd0, 16'd1, 16'd1, 8'd255, 10'd1023);
        1: set_phase(4'd14, 16'd0, 16'd0, 8'd1, 10'd0);
        2: set_phase(4'(NO_ID_CODE), 16'($urandom_range(1, 12)), 16'($urandom_range(2, 40)),
                     8'($urandom_range(1, 8)), 10'($urandom_range(0, 40)));
        default: set_phase(4'($urandom_range(0, 15)), 16'($urandom_range(1, 12)),
                           16'($urandom_range(2, 40)), 8'($urandom_range(0, 8)),
                           10'($urandom_range(0, 40)));
      endcase
      // long receiver hold-off while ticks keep coming
      if (k == 3) stall_req = 1'b1;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) begin
        case ($urandom_range(0, 7))
          0, 1: noise_burst();
          2: begin
            settle();
            session();
          end
          default: session();
        endcase
      end
    end

    settle();
    if (fails == 0) begin
      $display("button_node_id_setter regression: pass");
    end else begin
      $display("button_node_id_setter regression: fail");
    end
    $finish;
  end

endmodule
